// ===== sv/jse_pkg.sv =====
`default_nettype none

package jse_pkg;

    // Input kinds carried on tuser
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam int MAX_OUT  = 15;
    localparam int TAIL_MAX = 6;
    localparam int HELD_MAX = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // U+FFFD in UTF-8, first byte in the low bits
    localparam logic [23:0] REPL_SEQ = {8'hBD, 8'hBF, 8'hEF};

    typedef struct packed {
        logic [HELD_MAX-1:0][7:0] bytes;
        logic [1:0]               count;
        logic [2:0]               seq_len;
    } t_held;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [3:0]              count;
        t_held                   held;
    } t_expand;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v < 4'd10) ? (8'h30 + w) : (8'h57 + w);
    endfunction

endpackage

`default_nettype wire

// ===== sv/jse_expand.sv =====
`default_nettype none

module jse_expand (
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_byte,
    input  jse_pkg::t_held   i_held,
    output jse_pkg::t_expand o_exp
);
    import jse_pkg::*;

    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_SURR = 8'hED;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] E0_MIN    = 8'hA0;
    localparam logic [7:0] ED_MAX    = 8'h9F;
    localparam logic [7:0] F0_MIN    = 8'h90;
    localparam logic [7:0] F4_MAX    = 8'h8F;

    logic [TAIL_MAX-1:0][7:0] f_bytes;
    logic [2:0]               f_cnt;
    logic                     f_lead;
    logic [2:0]               f_len;
    logic [TAIL_MAX-1:0][7:0] t_bytes;
    logic [2:0]               t_cnt;
    logic [1:0]               pre_n;
    logic [7:0]               lo;
    logic [7:0]               hi;
    logic                     in_seq;
    logic                     in_range;
    logic                     seq_done;

    // Output of a byte seen with no sequence in progress
    always_comb begin
        f_bytes = '0;
        f_cnt   = 3'd0;
        f_lead  = 1'b0;
        f_len   = 3'd0;
        if (!i_byte[7]) begin
            case (i_byte)
                CH_QUOTE: begin
                    f_bytes[0] = CH_BSLASH;
                    f_bytes[1] = CH_QUOTE;
                    f_cnt      = 3'd2;
                end
                CH_BSLASH: begin
                    f_bytes[0] = CH_BSLASH;
                    f_bytes[1] = CH_BSLASH;
                    f_cnt      = 3'd2;
                end
                CH_NL: begin
                    f_bytes[0] = CH_BSLASH;
                    f_bytes[1] = CH_LOW_N;
                    f_cnt      = 3'd2;
                end
                CH_CR: begin
                    f_bytes[0] = CH_BSLASH;
                    f_bytes[1] = CH_LOW_R;
                    f_cnt      = 3'd2;
                end
                CH_TAB: begin
                    f_bytes[0] = CH_BSLASH;
                    f_bytes[1] = CH_LOW_T;
                    f_cnt      = 3'd2;
                end
                default: begin
                    if (i_byte < CH_SPACE || i_byte == CH_DEL) begin
                        f_bytes[0] = CH_BSLASH;
                        f_bytes[1] = CH_LOW_U;
                        f_bytes[2] = CH_ZERO;
                        f_bytes[3] = CH_ZERO;
                        f_bytes[4] = hex_digit(i_byte[7:4]);
                        f_bytes[5] = hex_digit(i_byte[3:0]);
                        f_cnt      = 3'd6;
                    end else begin
                        f_bytes[0] = i_byte;
                        f_cnt      = 3'd1;
                    end
                end
            endcase
        end else if (i_byte >= LEAD2_MIN && i_byte <= LEAD2_MAX) begin
            f_lead = 1'b1;
            f_len  = 3'd2;
        end else if (i_byte >= LEAD3_MIN && i_byte <= LEAD3_MAX) begin
            f_lead = 1'b1;
            f_len  = 3'd3;
        end else if (i_byte >= LEAD4_MIN && i_byte <= LEAD4_MAX) begin
            f_lead = 1'b1;
            f_len  = 3'd4;
        end else begin
            f_bytes[0] = REPL_SEQ[7:0];
            f_bytes[1] = REPL_SEQ[15:8];
            f_bytes[2] = REPL_SEQ[23:16];
            f_cnt      = 3'd3;
        end
    end

    always_comb begin
        in_seq = (i_held.count != 2'd0) && (i_held.seq_len >= 3'd2)
                 && ({1'b0, i_held.count} < i_held.seq_len);
        lo = CONT_MIN;
        hi = CONT_MAX;
        // The second byte of a few lead bytes has a narrower range
        if (i_held.count == 2'd1) begin
            if (i_held.bytes[0] == LEAD3_MIN) lo = E0_MIN;
            if (i_held.bytes[0] == LEAD_SURR) hi = ED_MAX;
            if (i_held.bytes[0] == LEAD4_MIN) lo = F0_MIN;
            if (i_held.bytes[0] == LEAD4_MAX) hi = F4_MAX;
        end
        in_range = (i_byte >= lo) && (i_byte <= hi);
        seq_done = ({1'b0, i_held.count} + 3'd1) == i_held.seq_len;
    end

    always_comb begin
        o_exp      = '0;
        o_exp.held = i_held;
        t_bytes    = f_bytes;
        t_cnt      = f_cnt;
        pre_n      = 2'd0;
        unique case (i_mode)
            MODE_DATA: begin
                if (in_seq && in_range && seq_done) begin
                    // Sequence complete: pass held bytes and this one
                    t_bytes    = '0;
                    t_bytes[0] = i_held.bytes[0];
                    case (i_held.count)
                        2'd1: t_bytes[1] = i_byte;
                        2'd2: begin
                            t_bytes[1] = i_held.bytes[1];
                            t_bytes[2] = i_byte;
                        end
                        default: begin
                            t_bytes[1] = i_held.bytes[1];
                            t_bytes[2] = i_held.bytes[2];
                            t_bytes[3] = i_byte;
                        end
                    endcase
                    t_cnt              = {1'b0, i_held.count} + 3'd1;
                    o_exp.held.count   = 2'd0;
                    o_exp.held.seq_len = 3'd0;
                end else if (in_seq && in_range) begin
                    t_cnt = 3'd0;
                    if (i_held.count == 2'd1) begin
                        o_exp.held.bytes[1] = i_byte;
                    end else begin
                        o_exp.held.bytes[2] = i_byte;
                    end
                    o_exp.held.count = i_held.count + 2'd1;
                end else begin
                    // Flush a rejected sequence, then start over with this byte
                    pre_n = in_seq ? i_held.count : 2'd0;
                    if (f_lead) begin
                        o_exp.held.bytes[0] = i_byte;
                        o_exp.held.count    = 2'd1;
                        o_exp.held.seq_len  = f_len;
                    end else begin
                        o_exp.held.count   = 2'd0;
                        o_exp.held.seq_len = 3'd0;
                    end
                end
            end
            MODE_BEGIN: begin
                t_bytes            = '0;
                t_bytes[0]         = CH_QUOTE;
                t_cnt              = 3'd1;
                o_exp.held.count   = 2'd0;
                o_exp.held.seq_len = 3'd0;
            end
            MODE_END: begin
                pre_n              = i_held.count;
                t_bytes            = '0;
                t_bytes[0]         = CH_QUOTE;
                t_cnt              = 3'd1;
                o_exp.held.count   = 2'd0;
                o_exp.held.seq_len = 3'd0;
            end
            default: begin
                t_bytes = '0;
                t_cnt   = 3'd0;
            end
        endcase

        case (pre_n)
            2'd0:    o_exp.bytes = {72'h0, t_bytes};
            2'd1:    o_exp.bytes = {48'h0, t_bytes, REPL_SEQ};
            2'd2:    o_exp.bytes = {24'h0, t_bytes, REPL_SEQ, REPL_SEQ};
            default: o_exp.bytes = {t_bytes, REPL_SEQ, REPL_SEQ, REPL_SEQ};
        endcase
        o_exp.count = (4'(pre_n) * 4'd3) + {1'b0, t_cnt};
    end

endmodule

`default_nettype wire

// ===== sv/json_string_escaper_utf8_top.sv =====
// An accepted item waits in the input register until the output buffer is free,
// then is expanded and loaded into the buffer. Throughput: one item per cycle
// while each item yields at most one byte and the receiver takes every byte;
// an item with more output bytes holds the buffer until all have been taken.
// Reset: i_rst_n is synchronous, active low; it empties both stages and
// drops any partly received UTF-8 sequence.
`default_nettype none

module json_string_escaper_utf8_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0] i_s_axis_tuser,   // [1:0] mode
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast
);
    import jse_pkg::*;

    logic                    r_in_valid;
    logic                    n_in_valid;
    logic [1:0]              r_in_mode;
    logic [1:0]              n_in_mode;
    logic [7:0]              r_in_byte;
    logic [7:0]              n_in_byte;
    t_held                   r_held;
    t_held                   n_held;
    logic [MAX_OUT-1:0][7:0] r_buf;
    logic [MAX_OUT-1:0][7:0] n_buf;
    logic [3:0]              r_cnt;
    logic [3:0]              n_cnt;
    t_expand                 exp_res;
    logic                    s_accept;
    logic                    pop;
    logic                    buf_free;
    logic                    load;

    jse_expand u_expand (
        .i_mode (r_in_mode),
        .i_byte (r_in_byte),
        .i_held (r_held),
        .o_exp  (exp_res)
    );

    assign o_m_axis_tvalid = (r_cnt != 4'd0);
    assign o_m_axis_tdata  = r_buf[0];
    assign o_m_axis_tlast  = (r_cnt == 4'd1);

    always_comb begin
        pop             = o_m_axis_tvalid && i_m_axis_tready;
        buf_free        = (r_cnt == 4'd0) || ((r_cnt == 4'd1) && i_m_axis_tready);
        load            = r_in_valid && buf_free;
        o_s_axis_tready = !r_in_valid || buf_free;
        s_accept        = i_s_axis_tvalid && o_s_axis_tready;

        n_in_valid = r_in_valid;
        n_in_mode  = r_in_mode;
        n_in_byte  = r_in_byte;
        if (s_accept) begin
            n_in_valid = 1'b1;
            n_in_mode  = i_s_axis_tuser;
            n_in_byte  = i_s_axis_tdata;
        end else if (load) begin
            n_in_valid = 1'b0;
        end

        n_held = load ? exp_res.held : r_held;

        n_buf = r_buf;
        n_cnt = r_cnt;
        if (load) begin
            n_buf = exp_res.bytes;
            n_cnt = exp_res.count;
        end else if (pop) begin
            // advance to the next byte
            n_buf = {8'h00, r_buf[MAX_OUT-1:1]};
            n_cnt = r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_mode    <= n_in_mode;
        r_in_byte    <= n_in_byte;
        r_buf        <= n_buf;
        r_held.bytes <= n_held.bytes;
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_cnt          <= 4'd0;
            r_held.count   <= 2'd0;
            r_held.seq_len <= 3'd0;
        end else begin
            r_in_valid     <= n_in_valid;
            r_cnt          <= n_cnt;
            r_held.count   <= n_held.count;
            r_held.seq_len <= n_held.seq_len;
        end
    end

    a_held_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held.count != 2'd0) |->
            (r_held.seq_len >= 3'd2 && {1'b0, r_held.count} < r_held.seq_len))
        else $error("held count does not fit the sequence length");

    a_begin_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_mode == MODE_BEGIN) |=>
            (o_m_axis_tvalid && o_m_axis_tdata == CH_QUOTE && o_m_axis_tlast))
        else $error("begin item did not yield a single quote");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && o_m_axis_tlast && !load) |=> !o_m_axis_tvalid)
        else $error("output still valid after last byte without a new item");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_cnt > 4'd1) |=> r_in_valid)
        else $error("pending item dropped while output busy");

endmodule

`default_nettype wire

// ===== dv/json_string_escaper_utf8_top_test.sv =====
`default_nettype none

module json_string_escaper_utf8_top_test;
    import jse_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 140;
    localparam int HOLD_CYCLES  = 150;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
    logic [1:0] s_tuser = 2'd0;    // [1:0] mode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;

    // escaper state as predicted
    logic [7:0] utf_held [3] = '{8'h00, 8'h00, 8'h00};
    logic [1:0] utf_count = 2'd0;
    logic [2:0] utf_len = 3'd0;

    logic [7:0] esc_bytes [$];
    logic [7:0] exp_byte [$];
    logic       exp_last [$];
    logic [7:0] want_byte;
    logic       want_last;

    int err_count = 0;
    int out_seen = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    rx_style_t  rx_style = RX_ALWAYS;
    int         hold_left = 0;
    logic [7:0] rx_mask = 8'hFF;
    logic [2:0] rx_phase = 3'd0;

    always #4 i_clk = ~i_clk;

    json_string_escaper_utf8_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // Bounds on the byte right after a lead byte
    function automatic logic [7:0] second_lo(input logic [7:0] lead);
        if (lead == 8'hE0) return 8'hA0;
        if (lead == 8'hF0) return 8'h90;
        return 8'h80;
    endfunction

    function automatic logic [7:0] second_hi(input logic [7:0] lead);
        if (lead == 8'hED) return 8'h9F;
        if (lead == 8'hF4) return 8'h8F;
        return 8'hBF;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v < 4'd10) ? (8'h30 + w) : (8'h61 + w - 8'd10);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        esc_bytes.push_back(b);
    endtask

    task automatic put_replacement();
        put_byte(REPL_SEQ[7:0]);
        put_byte(REPL_SEQ[15:8]);
        put_byte(REPL_SEQ[23:16]);
    endtask

    task automatic drop_held();
        for (int k = 0; k < 3; k++) utf_held[k] = 8'h00;
        utf_count = 2'd0;
        utf_len = 3'd0;
    endtask

    task automatic flush_held();
        for (int k = 0; k < utf_count; k++) put_replacement();
        drop_held();
    endtask

    task automatic start_fresh(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80) begin
            case (b)
                CH_QUOTE:  begin put_byte(CH_BSLASH); put_byte(CH_QUOTE); end
                CH_BSLASH: begin put_byte(CH_BSLASH); put_byte(CH_BSLASH); end
                CH_NL:     begin put_byte(CH_BSLASH); put_byte(CH_LOW_N); end
                CH_CR:     begin put_byte(CH_BSLASH); put_byte(CH_LOW_R); end
                CH_TAB:    begin put_byte(CH_BSLASH); put_byte(CH_LOW_T); end
                default: begin
                    if (b < CH_SPACE || b == CH_DEL) begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_LOW_U);
                        put_byte(CH_ZERO);
                        put_byte(CH_ZERO);
                        put_byte(nibble_char(b[7:4]));
                        put_byte(nibble_char(b[3:0]));
                    end else begin
                        put_byte(b);
                    end
                end
            endcase
        end else begin
            if (b >= 8'hC2 && b <= 8'hDF) len = 3'd2;
            else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
            else if (b >= 8'hF0 && b <= 8'hF4) len = 3'd4;
            else len = 3'd0;
            if (len == 3'd0) begin
                put_replacement();
            end else begin
                utf_len = len;
                utf_held[0] = b;
                utf_count = 2'd1;
            end
        end
    endtask

    task automatic feed_data(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (utf_count == 0 || utf_len < 2 || utf_count >= utf_len) begin
            drop_held();
            start_fresh(b);
        end else begin
            if (utf_count == 1) begin
                lo = second_lo(utf_held[0]);
                hi = second_hi(utf_held[0]);
            end
            if (b < lo || b > hi) begin
                flush_held();
                start_fresh(b);
            end else if (utf_count + 1 == utf_len) begin
                for (int k = 0; k < utf_count; k++) put_byte(utf_held[k]);
                put_byte(b);
                drop_held();
            end else begin
                utf_held[utf_count] = b;
                utf_count = utf_count + 2'd1;
            end
        end
    endtask

    task automatic predict_escape(input logic [1:0] mode, input logic [7:0] b);
        esc_bytes.delete();
        case (mode)
            MODE_DATA:  feed_data(b);
            MODE_BEGIN: begin drop_held(); put_byte(CH_QUOTE); end
            MODE_END:   begin flush_held(); put_byte(CH_QUOTE); end
            default: ;
        endcase
        foreach (esc_bytes[i]) begin
            exp_byte.push_back(esc_bytes[i]);
            exp_last.push_back(i == esc_bytes.size() - 1);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at output %0d: %s got %02h want %02h",
                 out_seen, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (exp_byte.size() == 0) begin
                report_mismatch("item with nothing expected", m_tdata, 8'h00);
            end else begin
                want_byte = exp_byte.pop_front();
                want_last = exp_last.pop_front();
                if (m_tdata !== want_byte) report_mismatch("tdata", m_tdata, want_byte);
                if (m_tlast !== want_last)
                    report_mismatch("tlast", {7'd0, m_tlast}, {7'd0, want_last});
            end
            out_seen++;
        end
    end

    // Receiver: hold-off first, then the current stall style
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                case (rx_style)
                    RX_ALWAYS: m_tready = 1'b1;
                    RX_RANDOM: m_tready = ($urandom_range(0, 99) < 65);
                    default: begin
                        m_tready = rx_mask[rx_phase];
                        rx_phase = rx_phase + 3'd1;
                    end
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("json_string_escaper_utf8_top regression: fail");
        $finish;
    end

    // Called just after a falling edge; returns just after a falling edge, once the item has been accepted
    task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = mode;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_escape(mode, b);
        if (mode != MODE_SPARE) items_sent++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(MODE_DATA, b);
    endtask

    task automatic wait_drain();
        while (exp_byte.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_utf8_char(input int len);
        logic [7:0] lead;
        case (len)
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_byte(lead);
        send_byte(8'($urandom_range(second_lo(lead), second_hi(lead))));
        for (int k = 2; k < len; k++) send_byte(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    // Valid lead, some valid continuation, then a bad byte, an end or a begin
    task automatic send_broken_seq();
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] bad;
        int len;
        int good;
        int sel;
        len = $urandom_range(2, 4);
        case (len)
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        good = $urandom_range(0, len - 2);
        send_byte(lead);
        for (int k = 0; k < good; k++) begin
            if (k == 0) send_byte(8'($urandom_range(second_lo(lead), second_hi(lead))));
            else send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        lo = (good == 0) ? second_lo(lead) : 8'h80;
        hi = (good == 0) ? second_hi(lead) : 8'hBF;
        sel = $urandom_range(0, 5);
        if (sel == 4) begin
            send_item(MODE_END, 8'($urandom));
        end else if (sel == 5) begin
            send_item(MODE_BEGIN, 8'($urandom));
        end else begin
            // near misses around the allowed range are the interesting ones
            if (sel == 0 && lo > 8'h80) bad = lo - 8'd1;
            else if (sel == 1 && hi < 8'hBF) bad = hi + 8'd1;
            else begin
                bad = 8'($urandom);
                while (bad >= lo && bad <= hi) bad = 8'($urandom);
            end
            send_byte(bad);
        end
    endtask

    task automatic send_piece();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (r < 50) begin
            case ($urandom_range(0, 6))
                0: send_byte(CH_QUOTE);
                1: send_byte(CH_BSLASH);
                2: send_byte(CH_NL);
                3: send_byte(CH_CR);
                4: send_byte(CH_TAB);
                5: send_byte(CH_DEL);
                default: send_byte(8'($urandom_range(8'h00, 8'h1F)));
            endcase
        end else if (r < 75) begin
            send_utf8_char($urandom_range(2, 4));
        end else if (r < 88) begin
            send_broken_seq();
        end else if (r < 96) begin
            send_byte(8'($urandom));
        end else begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    task automatic test_directed_escapes();
        rx_style = RX_RANDOM;
        gaps_on = 1'b1;
        send_item(MODE_BEGIN, 8'hFF);
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_NL);
        send_byte(CH_CR);
        send_byte(CH_TAB);
        send_byte(8'h00);
        send_byte(CH_DEL);
        send_byte(8'h7E);
        wait_drain();
    endtask

    task automatic test_directed_utf8();
        rx_style = RX_PATTERN;
        rx_mask = 8'b1011_0110;
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
        // overlong, surrogate, above U+10FFFF, invalid lead
        send_byte(8'hE0); send_byte(8'h9F);
        send_byte(8'hED); send_byte(8'hA0);
        send_byte(8'hF4); send_byte(8'h90);
        send_byte(8'hFF);
        // truncated at end of string, then data with no begin
        send_byte(8'hE2); send_byte(8'h82);
        send_item(MODE_END, 8'h00);
        send_byte(8'h41);
        // begin drops a held lead without output
        send_byte(8'hF0);
        send_item(MODE_BEGIN, 8'hA5);
        send_item(MODE_SPARE, 8'h5A);
        send_item(MODE_END, 8'hFF);
        wait_drain();
    endtask

    task automatic test_random_text();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            rx_style = rx_style_t'($urandom_range(0, 2));
            rx_mask = 8'($urandom_range(1, 255));
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) != 0) send_item(MODE_BEGIN, 8'($urandom));
            repeat ($urandom_range(1, 12)) send_piece();
            if ($urandom_range(0, 9) != 0) send_item(MODE_END, 8'($urandom));
            if ($urandom_range(0, 7) == 0) wait_drain();
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        rx_style = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_left = HOLD_CYCLES;
        // control bytes expand to six output bytes, but tab, newline and carriage return to two
        send_item(MODE_BEGIN, 8'($urandom));
        repeat (30) send_byte(8'($urandom_range(8'h00, 8'h1F)));
        send_utf8_char(4);
        send_item(MODE_END, 8'($urandom));
        wait_drain();
        rx_style = RX_RANDOM;
        gaps_on = 1'b1;
        send_item(MODE_BEGIN, 8'($urandom));
        repeat (6) send_piece();
        send_item(MODE_END, 8'($urandom));
        wait_drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_escapes();
        test_directed_utf8();
        test_random_text();
        test_backpressure();
        rx_style = RX_ALWAYS;
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0 && exp_byte.size() == 0) begin
            $display("json_string_escaper_utf8_top regression: pass");
        end else begin
            $display("json_string_escaper_utf8_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/jse_pkg.sv
sv/jse_expand.sv
sv/json_string_escaper_utf8_top.sv
dv/json_string_escaper_utf8_top_test.sv
